/* hdl/jfc_pkg.sv */
`timescale 1ns / 1ps

package jfc_pkg;

    // chunk size limits and register reset
    localparam int          MAX_CHUNK_DEF = 4096;
    localparam int          CFG_W         = 13;
    localparam logic [12:0] CHUNK_RESET   = 13'd1400;

    // field widths
    localparam int PAD_W   = 12;
    localparam int DROPS_W = 16;
    localparam int MOD_W   = 7;

    // marker bytes
    localparam logic [7:0] BYTE_MARK = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_EOI  = 8'hD9;

    // drop counter limits and warning period
    localparam logic [DROPS_W-1:0] DROP_MAX    = 16'hFFFF;
    localparam logic [MOD_W-1:0]   WARN_LAST   = 7'd119;

    // input modes and result kinds
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    // one result item
    typedef struct packed {
        logic               kind;
        logic [7:0]         out_byte;
        logic               chunk_last;
        logic               frame_end;
        logic [PAD_W-1:0]   pad_count;
        logic [DROPS_W-1:0] drops;
        logic               warn;
        logic               last;
    } t_result;

    // results produced by one accepted input
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

/* hdl/jfc_ifs.sv */
`timescale 1ns / 1ps

// camera stream input channel
interface jfc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

// result channel
interface jfc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [7:0]                  out_byte;
    logic                        chunk_last;
    logic                        frame_end;
    logic [jfc_pkg::PAD_W-1:0]   pad_count;
    logic [jfc_pkg::DROPS_W-1:0] drops;
    logic                        warn;
    logic                        last;

    modport source (output valid, output kind, output out_byte, output chunk_last,
                    output frame_end, output pad_count, output drops, output warn,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input chunk_last,
                    input frame_end, input pad_count, input drops, input warn,
                    input last, output ready);
endinterface

// chunk length register write channel
interface jfc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [jfc_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/jfc_parse.sv */
`timescale 1ns / 1ps

module jfc_parse #(
    parameter int MAX_CHUNK = jfc_pkg::MAX_CHUNK_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_mode,
    input  logic [7:0]                i_in_byte,
    input  logic [jfc_pkg::CFG_W-1:0] i_chunk_length,
    output jfc_pkg::t_push            o_push
);

    localparam int CLOG_LEN = $clog2(MAX_CHUNK + 1);
    localparam int LW       = (CLOG_LEN > jfc_pkg::CFG_W) ? CLOG_LEN : jfc_pkg::CFG_W;
    localparam int PW       = $clog2(MAX_CHUNK);

    logic                        r_held,     n_held;
    logic                        r_in_frame, n_in_frame;
    logic                        r_disc,     n_disc;
    logic [PW-1:0]               r_pos,      n_pos;
    logic [jfc_pkg::DROPS_W-1:0] r_drops,    n_drops;
    logic [jfc_pkg::MOD_W-1:0]   r_mod,      n_mod;

    logic [LW-1:0] w_cfg;
    logic [LW-1:0] w_eff;
    logic [LW-1:0] w_d_pos;
    logic [LW-1:0] w_d_diff;
    logic          w_ends;
    logic          w_d_cl;
    logic          w_s1_cl;
    logic [LW-1:0] w_s2_pos;
    logic          w_s2_cl;

    // effective chunk length, clamped to 1..MAX_CHUNK
    assign w_cfg = LW'(i_chunk_length);
    assign w_eff = (w_cfg == '0) ? LW'(1) :
                   (w_cfg > LW'(MAX_CHUNK)) ? LW'(MAX_CHUNK) : w_cfg;

    // in-frame data byte
    assign w_ends   = r_held && (i_in_byte == jfc_pkg::BYTE_EOI);
    assign w_d_pos  = LW'(r_pos) + LW'(1);
    assign w_d_cl   = w_ends || (w_d_pos >= w_eff);
    assign w_d_diff = w_eff - w_d_pos;

    // frame start: FF then D8 as the first two bytes of the frame
    assign w_s1_cl  = (w_eff == LW'(1));
    assign w_s2_pos = w_s1_cl ? LW'(1) : LW'(2);
    assign w_s2_cl  = (w_s2_pos >= w_eff);

    // next state and results for the accepted item
    always_comb begin
        n_held     = r_held;
        n_in_frame = r_in_frame;
        n_disc     = r_disc;
        n_pos      = r_pos;
        n_drops    = r_drops;
        n_mod      = r_mod;
        o_push     = '0;
        if (i_accept) begin
            if (i_mode == jfc_pkg::MODE_TIMEOUT) begin
                if (r_in_frame && !r_disc) begin
                    n_disc = 1'b1;
                    n_pos  = '0;
                    if (r_drops != jfc_pkg::DROP_MAX) begin
                        n_drops = r_drops + 1'b1;
                        n_mod   = (r_mod == jfc_pkg::WARN_LAST) ? '0 : r_mod + 1'b1;
                    end
                    o_push.count      = 2'd1;
                    o_push.first.kind = jfc_pkg::KIND_DROP;
                    o_push.first.drops = n_drops;
                    o_push.first.warn = (n_drops == jfc_pkg::DROPS_W'(1)) || (n_mod == '0);
                    o_push.first.last = 1'b1;
                end
            end else if (!r_in_frame) begin
                if (r_held && (i_in_byte == jfc_pkg::BYTE_SOI)) begin
                    n_in_frame = 1'b1;
                    n_disc     = 1'b0;
                    n_held     = 1'b0;
                    n_pos      = w_s2_cl ? '0 : PW'(w_s2_pos);
                    if (w_s1_cl || w_s2_cl) begin
                        n_drops = '0;
                        n_mod   = '0;
                    end
                    o_push.count             = 2'd2;
                    o_push.first.kind        = jfc_pkg::KIND_DATA;
                    o_push.first.out_byte    = jfc_pkg::BYTE_MARK;
                    o_push.first.chunk_last  = w_s1_cl;
                    o_push.first.drops       = w_s1_cl ? '0 : r_drops;
                    o_push.second.kind       = jfc_pkg::KIND_DATA;
                    o_push.second.out_byte   = jfc_pkg::BYTE_SOI;
                    o_push.second.chunk_last = w_s2_cl;
                    o_push.second.drops      = (w_s1_cl || w_s2_cl) ? '0 : r_drops;
                    o_push.second.last       = 1'b1;
                end else begin
                    n_held = (i_in_byte == jfc_pkg::BYTE_MARK);
                end
            end else begin
                if (!r_disc) begin
                    n_pos = w_d_cl ? '0 : PW'(w_d_pos);
                    if (w_d_cl) begin
                        n_drops = '0;
                        n_mod   = '0;
                    end
                    o_push.count            = 2'd1;
                    o_push.first.kind       = jfc_pkg::KIND_DATA;
                    o_push.first.out_byte   = i_in_byte;
                    o_push.first.chunk_last = w_d_cl;
                    o_push.first.frame_end  = w_ends;
                    o_push.first.pad_count  = (w_ends && (w_d_pos < w_eff)) ?
                                              w_d_diff[jfc_pkg::PAD_W-1:0] : '0;
                    o_push.first.drops      = w_d_cl ? '0 : r_drops;
                    o_push.first.last       = 1'b1;
                end
                if (w_ends) begin
                    n_in_frame = 1'b0;
                    n_disc     = 1'b0;
                    n_pos      = '0;
                    n_held     = 1'b0;
                end else begin
                    n_held = (i_in_byte == jfc_pkg::BYTE_MARK);
                end
            end
        end
    end

    // framing and drop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 1'b0;
            r_in_frame <= 1'b0;
            r_disc     <= 1'b0;
            r_pos      <= '0;
            r_drops    <= '0;
            r_mod      <= '0;
        end else begin
            r_held     <= n_held;
            r_in_frame <= n_in_frame;
            r_disc     <= n_disc;
            r_pos      <= n_pos;
            r_drops    <= n_drops;
            r_mod      <= n_mod;
        end
    end

endmodule

/* hdl/jfc_out_queue.sv */
`timescale 1ns / 1ps

module jfc_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jfc_pkg::t_push   i_push,
    input  logic             i_pop_ready,
    output jfc_pkg::t_result o_head,
    output logic             o_valid,
    output logic             o_space,
    output logic [1:0]       o_count
);

    jfc_pkg::t_result r_entry [3];
    jfc_pkg::t_result n_entry [3];
    logic [1:0]       r_count, n_count;
    logic             w_pop;
    logic [1:0]       w_kept;

    assign w_pop   = (r_count != 2'd0) && i_pop_ready;
    assign w_kept  = r_count - {1'b0, w_pop};
    assign o_space = (w_kept <= 2'd1);
    assign o_head  = r_entry[0];
    assign o_valid = (r_count != 2'd0);
    assign o_count = r_count;
    assign n_count = w_kept + i_push.count;

    // shift out the head on a transfer, then place new results behind what is kept
    always_comb begin
        n_entry[0] = w_pop ? r_entry[1] : r_entry[0];
        n_entry[1] = w_pop ? r_entry[2] : r_entry[1];
        n_entry[2] = r_entry[2];
        for (int k = 0; k < 3; k++) begin
            if ((i_push.count != 2'd0) && (w_kept == 2'(k))) begin
                n_entry[k] = i_push.first;
            end
            if ((i_push.count == 2'd2) && (w_kept + 2'd1 == 2'(k))) begin
                n_entry[k] = i_push.second;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_entry[k] <= n_entry[k];
        end
    end

    // fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

/* hdl/jpeg_frame_chunker.sv */
`timescale 1ns / 1ps
// the first result of an input transfer is offered in the cycle after it when no results are waiting
// throughput: one input per cycle; a frame start puts two results into the three-entry
//   result queue, and input waits only in a cycle where two results would still be queued
//   after that cycle's output transfer, which happens only after output stalls
// reset (synchronous, active low): framing state, drop count and queue cleared,
//   chunk length back to 1400
module jpeg_frame_chunker #(
    parameter int MAX_CHUNK = jfc_pkg::MAX_CHUNK_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jfc_in_if.sink    i_in,
    jfc_cfg_if.sink   i_cfg,
    jfc_out_if.source o_out
);

    logic [jfc_pkg::CFG_W-1:0] r_chunk_length;
    jfc_pkg::t_push            w_push;
    jfc_pkg::t_result          w_head;
    logic                      w_space;
    logic                      w_accept;
    logic [1:0]                w_count;

    // chunk length register, always ready
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_length <= jfc_pkg::CHUNK_RESET;
        end else if (i_cfg.valid) begin
            r_chunk_length <= i_cfg.data;
        end
    end

    // input transfer whenever two result slots are free
    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    jfc_parse #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_mode         (i_in.mode),
        .i_in_byte      (i_in.in_byte),
        .i_chunk_length (r_chunk_length),
        .o_push         (w_push)
    );

    jfc_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop_ready (o_out.ready),
        .o_head      (w_head),
        .o_valid     (o_out.valid),
        .o_space     (w_space),
        .o_count     (w_count)
    );

    // result channel
    assign o_out.kind       = w_head.kind;
    assign o_out.out_byte   = w_head.out_byte;
    assign o_out.chunk_last = w_head.chunk_last;
    assign o_out.frame_end  = w_head.frame_end;
    assign o_out.pad_count  = w_head.pad_count;
    assign o_out.drops      = w_head.drops;
    assign o_out.warn       = w_head.warn;
    assign o_out.last       = w_head.last;

    // checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count != 2'd3 || !w_space || o_out.ready)
        else $error("result queue full while taking input");

    a_pair_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |=> o_out.valid)
        else $error("frame start results not offered");

    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == jfc_pkg::KIND_DROP) |->
        (o_out.last && o_out.pad_count == '0 && !o_out.chunk_last))
        else $error("malformed drop report");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> (o_out.chunk_last && o_out.last))
        else $error("frame end byte does not close its chunk");

endmodule
